### rtl/euler_path_check_macros.svh
// Assertion macros for the RTL files of the Euler path check.
`ifndef EULER_PATH_CHECK_MACROS_SVH
`define EULER_PATH_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define EPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("euler_path_check assertion failed");

// Implication checked at every clock edge outside reset.
`define EPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("euler_path_check assertion failed");

`else

`define EPC_ASSERT(lbl, clk, rst, prop)
`define EPC_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/epc_pkg.sv
package epc_pkg;

   localparam int VERTICES = 6;
   localparam int VTX_W    = 3;
   localparam int VIDX_W   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int CNT_W    = $clog2(VERTICES + 1);

   localparam logic [VTX_W-1:0]  VERT_MAX  = VTX_W'(VERTICES);
   localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VERTICES - 1);

   typedef logic [VERTICES-1:0] vmask_type;

   // Request to the edge store from the control logic.
   typedef struct packed {
      logic              add;
      logic              clear;
      logic [VTX_W-1:0]  end_a;
      logic [VTX_W-1:0]  end_b;
   } store_ctrl_type;

   // Status of the reachability sequencer.
   typedef struct packed {
      logic idle;
      logic done;
   } sweep_stat_type;

   // Vertex number (1-based) of the lowest set bit, 0 when the mask is empty.
   function automatic logic [VTX_W-1:0] lowest_vertex(input vmask_type mask);
      logic [VTX_W-1:0] res;
      res = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            res = VTX_W'(i + 1);
         end
      end
      return res;
   endfunction

   function automatic vmask_type lowest_bit(input vmask_type mask);
      return mask & (~mask + vmask_type'(1));
   endfunction

   function automatic logic [CNT_W-1:0] count_ones(input vmask_type mask);
      logic [CNT_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < VERTICES; i++) begin
         cnt = cnt + CNT_W'(mask[i]);
      end
      return cnt;
   endfunction

endpackage

### rtl/epc_store.sv
module epc_store import epc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  store_ctrl_type      ctrl,
   input  logic [VIDX_W-1:0]   row_idx,
   output vmask_type           row_data,
   output vmask_type           used,
   output vmask_type           odd
);

   vmask_type adj_ff [VERTICES];
   vmask_type adj_in [VERTICES];
   vmask_type odd_ff;
   vmask_type odd_in;

   logic      a_ok;
   logic      b_ok;
   vmask_type a_bit;
   vmask_type b_bit;

   assign a_ok  = (ctrl.end_a != '0) && (ctrl.end_a <= VERT_MAX);
   assign b_ok  = (ctrl.end_b != '0) && (ctrl.end_b <= VERT_MAX);
   assign a_bit = vmask_type'(1) << (ctrl.end_a - VTX_W'(1));
   assign b_bit = vmask_type'(1) << (ctrl.end_b - VTX_W'(1));

   always_comb begin
      for (int r = 0; r < VERTICES; r++) begin
         adj_in[r] = adj_ff[r];
      end
      odd_in = odd_ff;
      if (ctrl.clear) begin
         for (int r = 0; r < VERTICES; r++) begin
            adj_in[r] = '0;
         end
         odd_in = '0;
      end else if (ctrl.add && a_ok && b_ok) begin
         // A self loop sets its own bit and toggles its odd mark twice.
         for (int r = 0; r < VERTICES; r++) begin
            if (a_bit[r]) begin
               adj_in[r] = adj_in[r] | b_bit;
            end
            if (b_bit[r]) begin
               adj_in[r] = adj_in[r] | a_bit;
            end
         end
         odd_in = odd_ff ^ a_bit ^ b_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VERTICES; r++) begin
            adj_ff[r] <= '0;
         end
         odd_ff <= '0;
      end else begin
         for (int r = 0; r < VERTICES; r++) begin
            adj_ff[r] <= adj_in[r];
         end
         odd_ff <= odd_in;
      end
   end

   always_comb begin
      for (int r = 0; r < VERTICES; r++) begin
         used[r] = |adj_ff[r];
      end
   end

   assign row_data = adj_ff[row_idx];
   assign odd      = odd_ff;

endmodule

### rtl/epc_sweep.sv
module epc_sweep import epc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  vmask_type           start_mask,
   input  logic                release_done,
   input  vmask_type           row_data,
   output logic [VIDX_W-1:0]   row_idx,
   output vmask_type           reached,
   output sweep_stat_type      stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic [VIDX_W-1:0]  vidx_ff;
   logic [VIDX_W-1:0]  vidx_in;
   logic               grew_ff;
   logic               grew_in;
   vmask_type          reached_ff;
   vmask_type          reached_in;

   vmask_type          merged;
   logic               step_grew;

   // One row is folded into the reached set per cycle.
   assign merged    = reached_ff | (reached_ff[vidx_ff] ? row_data : '0);
   assign step_grew = (merged != reached_ff);

   always_comb begin
      state_in   = state_ff;
      vidx_in    = vidx_ff;
      grew_in    = grew_ff;
      reached_in = reached_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = S_RUN;
               vidx_in    = '0;
               grew_in    = 1'b0;
               reached_in = start_mask;
            end
         end
         S_RUN: begin
            reached_in = merged;
            if (vidx_ff == VIDX_LAST) begin
               vidx_in = '0;
               grew_in = 1'b0;
               // Another pass is needed only if this one added a vertex.
               if (!(grew_ff || step_grew)) begin
                  state_in = S_DONE;
               end
            end else begin
               vidx_in = vidx_ff + VIDX_W'(1);
               grew_in = grew_ff || step_grew;
            end
         end
         S_DONE: begin
            if (release_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vidx_ff  <= '0;
         grew_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         vidx_ff  <= vidx_in;
         grew_ff  <= grew_in;
      end
   end

   always_ff @(posedge clock) begin
      reached_ff <= reached_in;
   end

   assign row_idx   = vidx_ff;
   assign reached   = reached_ff;
   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);

endmodule

### rtl/euler_path_check.sv
// Euler path check over vertices 1..6. An add transaction (op = 0) loads one
// undirected edge; an edge with an endpoint outside 1..6 is dropped. An
// evaluate transaction (op = 1) starts a reachability sweep that folds one
// adjacency row per cycle into the reached set, in passes over all six rows,
// repeated until a pass adds no vertex. The answer is then loaded into the
// result register, but only once the previous result there, if any, has been
// accepted with rsp_tready. req_tready is low until that load.
// Each evaluate returns one result transaction and clears all loaded edges.
// first_end and second_end are the two odd-degree vertices in ascending order
// when the answer is yes and two such vertices exist, else 0.
`include "euler_path_check_macros.svh"

module euler_path_check import epc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] op, [3:1] end_a, [6:4] end_b, [7] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] path_exists, [3:1] first_end,
                                    // [6:4] second_end, [7] zero
);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   logic                req_op;
   logic [VTX_W-1:0]    req_end_a;
   logic [VTX_W-1:0]    req_end_b;
   logic                req_fire;

   store_ctrl_type      store_ctrl;
   logic [VIDX_W-1:0]   row_idx;
   vmask_type           row_data;
   vmask_type           used;
   vmask_type           odd;
   vmask_type           reached;
   sweep_stat_type      stat;

   logic                result_load;
   logic                answer;
   logic [CNT_W-1:0]    odd_count;
   logic                two_odd;
   logic [VTX_W-1:0]    lo_end;
   logic [VTX_W-1:0]    hi_end;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_exists_ff;
   logic [VTX_W-1:0]    rsp_first_ff;
   logic [VTX_W-1:0]    rsp_second_ff;

   assign req_op    = req_tdata[0];
   assign req_end_a = req_tdata[3:1];
   assign req_end_b = req_tdata[6:4];

   assign req_tready = stat.idle;
   assign req_fire   = req_tvalid && req_tready;

   // The result register must be free before the answer can be taken.
   assign result_load = stat.done && (!rsp_valid_ff || rsp_tready);

   assign store_ctrl.add   = req_fire && (req_op == OP_ADD);
   assign store_ctrl.clear = result_load;
   assign store_ctrl.end_a = req_end_a;
   assign store_ctrl.end_b = req_end_b;

   epc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (store_ctrl),
      .row_idx  (row_idx),
      .row_data (row_data),
      .used     (used),
      .odd      (odd)
   );

   epc_sweep u_sweep (
      .clock        (clock),
      .reset        (reset),
      .start        (req_fire && (req_op == OP_EVAL)),
      .start_mask   (lowest_bit(used)),
      .release_done (result_load),
      .row_data     (row_data),
      .row_idx      (row_idx),
      .reached      (reached),
      .stat         (stat)
   );

   assign odd_count = count_ones(odd);
   assign two_odd   = (odd_count == CNT_W'(2));
   assign answer    = (used != '0) && ((used & ~reached) == '0)
                      && ((odd_count == '0) || two_odd);
   assign lo_end    = lowest_vertex(odd);
   assign hi_end    = lowest_vertex(odd & ~lowest_bit(odd));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_exists_ff <= answer;
         rsp_first_ff  <= (answer && two_odd) ? lo_end : '0;
         rsp_second_ff <= (answer && two_odd) ? hi_end : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_second_ff, rsp_first_ff, rsp_exists_ff};

   `EPC_ASSERT_IMP(a_no_ends_on_no, clock, reset,
      rsp_valid_ff && !rsp_exists_ff, (rsp_first_ff == '0) && (rsp_second_ff == '0))
   `EPC_ASSERT_IMP(a_ends_ordered, clock, reset,
      rsp_valid_ff && (rsp_first_ff != '0), rsp_second_ff > rsp_first_ff)
   `EPC_ASSERT_IMP(a_cleared_after_eval, clock, reset,
      $past(result_load) && !$past(reset), (used == '0) && (odd == '0))
   `EPC_ASSERT_IMP(a_odd_even_count, clock, reset,
      stat.done, !odd_count[0])

endmodule

### tb/tb_euler_path_check.sv
module tb_euler_path_check;
   import epc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_PATTERN,
      RX_RANDOM
   } rx_mode_type;

   typedef struct {
      logic [7:0] data;
      bit         drain_first;
   } pending_item_type;

   typedef struct {
      logic       path_exists;
      logic [2:0] first_end;
      logic [2:0] second_end;
   } path_answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [0] op, [3:1] end_a, [6:4] end_b, [7] zero
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [0] path_exists, [3:1] first_end, [6:4] second_end

   pending_item_type pending_items[$];
   path_answer_type  expected_answers[$];

   // Graph as seen by the predictor: bit v-1 of a row stands for vertex v.
   vmask_type adj_rows [1:VERTICES];
   vmask_type odd_marks;

   int       error_count = 0;
   int       cycle_count = 0;
   int       items_queued = 0;
   bit       drain_next = 1'b0;
   int       gap_left = 0;
   int       burst_left = 4;
   int       rx_window = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   logic [15:0] rx_pattern = '1;

   euler_path_check uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic push_item(input logic op, input logic [2:0] a, input logic [2:0] b);
      pending_item_type it;
      it.data = {1'b0, b, a, op};
      it.drain_first = drain_next;
      drain_next = 1'b0;
      pending_items.push_back(it);
      items_queued++;
   endtask

   function automatic path_answer_type solve_path();
      path_answer_type ans;
      vmask_type used, reached, grown;
      int start, odd_count, lo, hi;
      bit grew;
      used = '0;
      reached = '0;
      start = 0;
      odd_count = 0;
      lo = 0;
      hi = 0;
      for (int v = 1; v <= VERTICES; v++) begin
         if (adj_rows[v] != '0) begin
            used[v-1] = 1'b1;
            if (start == 0) start = v;
         end
      end
      if (start != 0) begin
         reached[start-1] = 1'b1;
         do begin
            grown = reached;
            for (int v = 1; v <= VERTICES; v++) begin
               if (reached[v-1]) grown |= adj_rows[v];
            end
            grew = (grown != reached);
            reached = grown;
         end while (grew);
      end
      for (int v = 1; v <= VERTICES; v++) begin
         if (odd_marks[v-1]) begin
            odd_count++;
            if (odd_count == 1) lo = v;
            else if (odd_count == 2) hi = v;
         end
      end
      ans.path_exists = (start != 0) && ((used & ~reached) == '0)
                        && (odd_count == 0 || odd_count == 2);
      ans.first_end  = (ans.path_exists && odd_count == 2) ? 3'(lo) : 3'd0;
      ans.second_end = (ans.path_exists && odd_count == 2) ? 3'(hi) : 3'd0;
      return ans;
   endfunction

   task automatic apply_request(input logic [7:0] data);
      int a, b;
      a = data[3:1];
      b = data[6:4];
      if (data[0] == OP_ADD) begin
         // Edges touching a vertex outside 1..VERTICES are dropped.
         if (a >= 1 && a <= VERTICES && b >= 1 && b <= VERTICES) begin
            adj_rows[a][b-1] = 1'b1;
            adj_rows[b][a-1] = 1'b1;
            odd_marks[a-1] = ~odd_marks[a-1];
            odd_marks[b-1] = ~odd_marks[b-1];
         end
      end else begin
         expected_answers.push_back(solve_path());
         for (int v = 1; v <= VERTICES; v++) adj_rows[v] = '0;
         odd_marks = '0;
      end
   endtask

   task automatic check_result(input logic [7:0] data);
      path_answer_type want;
      if (expected_answers.size() == 0) begin
         report_mismatch("result transaction with none expected");
      end else begin
         want = expected_answers.pop_front();
         if (data[0] !== want.path_exists)
            report_mismatch($sformatf("path_exists got %0d expected %0d", data[0],
                                      want.path_exists));
         if (data[3:1] !== want.first_end)
            report_mismatch($sformatf("first_end got %0d expected %0d", data[3:1],
                                      want.first_end));
         if (data[6:4] !== want.second_end)
            report_mismatch($sformatf("second_end got %0d expected %0d", data[6:4],
                                      want.second_end));
      end
   endtask

   // Sender: bursts of transactions separated by random gaps.
   always @(posedge clock) begin : sender
      logic fire, present;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) void'(pending_items.pop_front());
         present = req_tvalid && !fire;
         if (!present && gap_left > 0) begin
            gap_left--;
         end else if (!present && pending_items.size() > 0
                      && (!pending_items[0].drain_first
                          || (!fire && expected_answers.size() == 0))) begin
            present = 1'b1;
            req_tdata <= pending_items[0].data;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_tvalid <= present;
      end
   end

   // Receiver: stall behavior changes from window to window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_window == 0) begin
            rx_window = $urandom_range(20, 200);
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_pattern = 16'($urandom);
         end
         rx_window--;
         rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_PATTERN: rsp_tready <= rx_pattern[0];
            default:    rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) apply_request(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int kind, n_edges, cur, nxt;
      for (int v = 1; v <= VERTICES; v++) adj_rows[v] = '0;
      odd_marks = '0;

      // Directed: empty store, single edge, self loop, dropped edges,
      // disconnected graph, cycle, four odd vertices, evaluate with junk ends.
      drain_next = 1'b1;
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd1, 3'd6);
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd3, 3'd3);
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd0, 3'd2);
      push_item(OP_ADD, 3'd7, 3'd7);
      push_item(OP_ADD, 3'd5, 3'd0);
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd1, 3'd2);
      push_item(OP_ADD, 3'd2, 3'd1);
      push_item(OP_ADD, 3'd4, 3'd5);
      push_item(OP_ADD, 3'd5, 3'd4);
      push_item(OP_EVAL, 3'd0, 3'd0);
      drain_next = 1'b1;
      push_item(OP_ADD, 3'd2, 3'd4);
      push_item(OP_ADD, 3'd4, 3'd6);
      push_item(OP_ADD, 3'd6, 3'd2);
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd1, 3'd2);
      push_item(OP_ADD, 3'd1, 3'd3);
      push_item(OP_ADD, 3'd1, 3'd4);
      push_item(OP_EVAL, 3'd0, 3'd0);
      push_item(OP_ADD, 3'd6, 3'd5);
      push_item(OP_ADD, 3'd5, 3'd4);
      push_item(OP_EVAL, 3'd7, 3'd7);

      // Random graphs: half are walks, occasionally with stray random edges, plus
      // loose edge sets and some with out-of-range endpoints.
      while (items_queued < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         n_edges = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 14) == 0) drain_next = 1'b1;
         cur = $urandom_range(1, VERTICES);
         for (int i = 0; i < n_edges; i++) begin
            if (kind < 5) begin
               nxt = $urandom_range(1, VERTICES);
               if ($urandom_range(0, 1) == 0) push_item(OP_ADD, 3'(cur), 3'(nxt));
               else push_item(OP_ADD, 3'(nxt), 3'(cur));
               cur = nxt;
               if ($urandom_range(0, 11) == 0)
                  push_item(OP_ADD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end else if (kind < 8) begin
               push_item(OP_ADD, 3'($urandom_range(1, VERTICES)),
                         3'($urandom_range(1, VERTICES)));
            end else begin
               push_item(OP_ADD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
         end
         push_item(OP_EVAL, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_answers.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_answers.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
      end
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
